### rtl/core/sbmm_pkg.sv
// Shared types and constants of the spatial bin max/mean accumulator.
// No dependencies.
`default_nettype none
package sbmm_pkg;

	localparam int DEF_NET_COUNT     = 4;
	localparam int DEF_GRID_SIDE_MAX = 64;
	localparam int DIV_STEPS         = 40;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FILTER  = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;
	localparam logic [1:0] ST_NOGEOM  = 2'd3;

	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_CPU_X    = 3'd2;
	localparam logic [2:0] CFG_CPU_Y    = 3'd3;
	localparam logic [2:0] CFG_COLUMNS  = 3'd4;
	localparam logic [2:0] CFG_ROWS     = 3'd5;
	localparam logic [2:0] CFG_FILTER   = 3'd6;
	localparam logic [2:0] CFG_READ_MAX = 3'd7;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_ADD  = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef struct packed {
		logic [29:0] origin_x;
		logic [29:0] origin_y;
		logic [31:0] cpu_x;
		logic [31:0] cpu_y;
		logic [6:0]  grid_columns;
		logic [6:0]  grid_rows;
		logic [1:0]  net_filter;
		logic        read_maximum;
	} cfg_t;

	typedef struct packed {
		op_t                op;
		logic [1:0]         status;
		logic               empty;
		logic signed [23:0] metric;
	} entry_t;

	typedef struct packed {
		logic signed [23:0] max;
		logic signed [39:0] sum;
		logic [15:0]        count;
	} cell_word_t;

endpackage
`default_nettype wire

### rtl/core/sbmm_front.sv
// Front end: takes one item, maps coordinates to a cell and classifies it.
// Depends on sbmm_pkg.
`default_nettype none
module sbmm_front #(
	parameter int NET_COUNT     = sbmm_pkg::DEF_NET_COUNT,
	parameter int GRID_SIDE_MAX = sbmm_pkg::DEF_GRID_SIDE_MAX,
	parameter int AW            = 14
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sbmm_pkg::cfg_t      cfg,
	input  wire                 clear_busy,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire                 mode,
	input  wire [1:0]           net_select,
	input  wire                 is_power,
	input  wire signed [30:0]   coord_x,
	input  wire signed [30:0]   coord_y,
	input  wire signed [23:0]   metric_value,
	input  wire [11:0]          read_cell,
	output logic                push,
	input  wire                 q_full,
	output sbmm_pkg::entry_t    push_entry,
	output logic [AW-1:0]       push_addr
);
	import sbmm_pkg::*;

	localparam int CELLS = GRID_SIDE_MAX * GRID_SIDE_MAX;
	localparam int IW    = $clog2(GRID_SIDE_MAX);
	localparam int SW    = $clog2(GRID_SIDE_MAX + 1);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_MUL  = 3'b010,
		F_MAP  = 3'b100
	} fstate_t;

	fstate_t            state_q;
	logic               mode_q, pwr_q;
	logic [1:0]         net_q;
	logic signed [30:0] cx_q, cy_q;
	logic signed [23:0] metric_q;
	logic [11:0]        rcell_q;
	logic [61:0]        prod_x_s1, prod_y_s1;
	logic               before_x_s1, before_y_s1;

	logic [30:0]   diff_x, diff_y;
	logic [SW-1:0] cols, rows;
	logic [45:0]   cell_x, cell_y;
	logic          in_x, in_y, net_ok, filt_ok;
	logic [IW-1:0] ix, iy;
	logic [31:0]   cell_idx;

	assign in_stall = (state_q != F_IDLE) || clear_busy;

	assign diff_x = {1'b0, cx_q[29:0]} - {1'b0, cfg.origin_x};
	assign diff_y = {1'b0, cy_q[29:0]} - {1'b0, cfg.origin_y};

	assign cols = (32'(cfg.grid_columns) > GRID_SIDE_MAX) ? SW'(GRID_SIDE_MAX)
		: SW'(cfg.grid_columns);
	assign rows = (32'(cfg.grid_rows) > GRID_SIDE_MAX) ? SW'(GRID_SIDE_MAX)
		: SW'(cfg.grid_rows);

	assign cell_x  = prod_x_s1[61:16];
	assign cell_y  = prod_y_s1[61:16];
	assign in_x    = !before_x_s1 && (cell_x < 46'(cols));
	assign in_y    = !before_y_s1 && (cell_y < 46'(rows));
	assign ix      = IW'(cell_x);
	assign iy      = IW'(cell_y);
	assign net_ok  = 32'(net_q) < NET_COUNT;
	assign filt_ok = pwr_q ? cfg.net_filter[0] : cfg.net_filter[1];

	always_comb begin
		push_entry        = '0;
		push_entry.op     = OP_NONE;
		push_entry.metric = metric_q;
		cell_idx          = 32'(iy) * 32'(cols) + 32'(ix);
		if (mode_q) begin
			cell_idx = 32'(rcell_q);
			if (!net_ok || (32'(rcell_q) >= 32'(cols) * 32'(rows))) begin
				push_entry.status = ST_OUTSIDE;
				push_entry.empty  = 1'b1;
			end else begin
				push_entry.op = OP_READ;
			end
		end else if (!filt_ok) begin
			push_entry.status = ST_FILTER;
		end else if (cx_q[30] || cy_q[30]) begin
			push_entry.status = ST_NOGEOM;
		end else if (!net_ok || !in_x || !in_y) begin
			push_entry.status = ST_OUTSIDE;
		end else begin
			push_entry.op = OP_ADD;
		end
		push_addr = AW'(32'(net_q) * CELLS + cell_idx);
	end

	assign push = (state_q == F_MAP) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (in_valid && !in_stall) state_q <= F_MUL;
				F_MUL:  state_q <= F_MAP;
				F_MAP:  if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid && !in_stall) begin
			mode_q   <= mode;
			net_q    <= net_select;
			pwr_q    <= is_power;
			cx_q     <= coord_x;
			cy_q     <= coord_y;
			metric_q <= metric_value;
			rcell_q  <= read_cell;
		end
		if (state_q == F_MUL) begin
			prod_x_s1   <= 62'(diff_x[29:0]) * 62'(cfg.cpu_x);
			prod_y_s1   <= 62'(diff_y[29:0]) * 62'(cfg.cpu_y);
			before_x_s1 <= diff_x[30];
			before_y_s1 <= diff_y[30];
		end
	end

endmodule
`default_nettype wire

### rtl/core/sbmm_queue.sv
// Two-entry queue between front and back end.
// Depends on sbmm_pkg only for import convention.
`default_nettype none
module sbmm_queue #(
	parameter int W = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire [W-1:0]  wdata,
	input  wire          pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	import sbmm_pkg::*;

	logic [W-1:0] slot_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

### rtl/core/sbmm_back.sv
// Back end: cell store with clearing pass, update, mean divider, output register.
// Depends on sbmm_pkg.
`default_nettype none
module sbmm_back #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               read_maximum,
	output logic              clear_busy,
	input  wire               q_empty,
	input  sbmm_pkg::entry_t  q_entry,
	input  wire [AW-1:0]      q_addr,
	output logic              pop,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [1:0]        status,
	output logic signed [23:0] cell_value,
	output logic              cell_empty
);
	import sbmm_pkg::*;

	typedef enum logic [4:0] {
		B_CLEAR = 5'b00001,
		B_IDLE  = 5'b00010,
		B_LOOK  = 5'b00100,
		B_DIV   = 5'b01000,
		B_RES   = 5'b10000
	} bstate_t;

	localparam cell_word_t RESET_WORD = '{max: 24'sh800000, sum: '0, count: '0};

	bstate_t            state_q;
	cell_word_t         mem [DEPTH];
	cell_word_t         rd_q;
	logic [AW-1:0]      clr_q, cur_addr_q;
	op_t                cur_op_q;
	logic signed [23:0] cur_metric_q;
	logic [1:0]         res_status_q;
	logic signed [23:0] res_value_q;
	logic               res_empty_q;
	logic [39:0]        num_q;
	logic [15:0]        rem_q, den_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	logic               out_valid_q;

	cell_word_t  upd;
	logic        we;
	logic [AW-1:0] wa;
	cell_word_t  wd;
	logic [16:0] rem_sh;
	logic        qbit;
	logic [39:0] num_next;
	logic        out_free;

	assign clear_busy = state_q == B_CLEAR;
	assign out_free   = !out_valid_q || !out_stall;
	assign pop        = (state_q == B_IDLE) && !q_empty;
	assign out_valid  = out_valid_q;

	always_comb begin
		upd = rd_q;
		if (cur_metric_q > rd_q.max) upd.max = cur_metric_q;
		if (rd_q.count != 16'hFFFF) begin
			upd.sum   = rd_q.sum + 40'(cur_metric_q);
			upd.count = rd_q.count + 16'd1;
		end
	end

	always_comb begin
		we = 1'b0;
		wa = cur_addr_q;
		wd = upd;
		if (state_q == B_CLEAR) begin
			we = 1'b1;
			wa = clr_q;
			wd = RESET_WORD;
		end else if (state_q == B_LOOK && cur_op_q == OP_ADD) begin
			we = 1'b1;
		end
	end

	// restoring divide, one quotient bit per cycle
	assign rem_sh   = {rem_q, num_q[39]};
	assign qbit     = rem_sh >= {1'b0, den_q};
	assign num_next = {num_q[38:0], qbit};

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (pop) rd_q <= mem[q_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == DEPTH - 1) state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (!q_empty) state_q <= (q_entry.op == OP_NONE) ? B_RES : B_LOOK;
				end
				B_LOOK: begin
					if (cur_op_q == OP_READ && rd_q.count != 16'd0 && !read_maximum)
						state_q <= B_DIV;
					else
						state_q <= B_RES;
				end
				B_DIV: if (cnt_q == 6'(DIV_STEPS - 1)) state_q <= B_RES;
				B_RES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cur_op_q     <= q_entry.op;
				cur_addr_q   <= q_addr;
				cur_metric_q <= q_entry.metric;
				res_status_q <= q_entry.status;
				res_empty_q  <= q_entry.empty;
				res_value_q  <= '0;
			end
			B_LOOK: begin
				if (cur_op_q == OP_READ) begin
					if (rd_q.count == 16'd0) res_empty_q <= 1'b1;
					else if (read_maximum) res_value_q <= rd_q.max;
				end
				neg_q <= rd_q.sum[39];
				num_q <= rd_q.sum[39] ? -rd_q.sum : rd_q.sum;
				den_q <= rd_q.count;
				rem_q <= '0;
				cnt_q <= '0;
			end
			B_DIV: begin
				num_q <= num_next;
				rem_q <= qbit ? 16'(rem_sh - {1'b0, den_q}) : rem_sh[15:0];
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1))
					res_value_q <= neg_q ? -num_next[23:0] : num_next[23:0];
			end
			B_RES: begin
				if (out_free) begin
					status     <= res_status_q;
					cell_value <= res_value_q;
					cell_empty <= res_empty_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/spatial_bin_max_mean_accumulator_unit.sv
// Top level of the spatial bin max/mean accumulator: config registers,
// front end, queue and back end. Depends on sbmm_pkg and the sbmm_* modules.
`default_nettype none
// Usage:
//  sample channel (sample_valid / sample_stall) carries one item: an add
//  (mode 0) bins a point into the selected net's grid; a read (mode 1)
//  returns one cell. Every item yields exactly one result item on the
//  result channel (result_valid / result_stall) with status, cell_value
//  and cell_empty.
//  Config port (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready;
//  write only while the block is idle.
//  Mean reads run through a 40-step restoring divider, one quotient bit
//  per cycle; adds, max reads and items that skip the store do not.
//  The front end takes one item at a time through its states (accept,
//  multiply, map) and stalls until it is back in accept and the clearing
//  pass is done; the back end handles one item at a time through the
//  single port cell store: adds and reads pass a look-up state, mean reads
//  then the divider, before the result state; items that skip the store go
//  straight to the result state. A two-entry queue decouples the two halves.
//  Reset: a clearing pass writes each of the NET_COUNT * GRID_SIDE_MAX^2
//  cells of the store (16384 by default), one per cycle; sample_stall is
//  high throughout, config writes are still taken.
//  When the receiver stalls, the result holds in the output register and
//  the back end waits; the front keeps filling the queue until it is full.
module spatial_bin_max_mean_accumulator_unit #(
	parameter int NET_COUNT     = sbmm_pkg::DEF_NET_COUNT,
	parameter int GRID_SIDE_MAX = sbmm_pkg::DEF_GRID_SIDE_MAX
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               sample_valid,
	output logic              sample_stall,
	input  wire               mode,
	input  wire [1:0]         net_select,
	input  wire               is_power,
	input  wire signed [30:0] coord_x,
	input  wire signed [30:0] coord_y,
	input  wire signed [23:0] metric_value,
	input  wire [11:0]        read_cell,
	output logic              result_valid,
	input  wire               result_stall,
	output logic [1:0]        status,
	output logic signed [23:0] cell_value,
	output logic              cell_empty,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire [2:0]         cfg_index,
	input  wire [31:0]        cfg_data
);
	import sbmm_pkg::*;

	localparam int DEPTH = NET_COUNT * GRID_SIDE_MAX * GRID_SIDE_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = $bits(entry_t) + AW;

	cfg_t          cfg_q;
	logic          clear_busy, push, pop, q_full, q_empty;
	entry_t        push_entry, pop_entry;
	logic [AW-1:0] push_addr, pop_addr;

	assign cfg_ready = 1'b1;

	// config registers, reset to the documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= '0;
			cfg_q.origin_y     <= '0;
			cfg_q.cpu_x        <= 32'd65536;
			cfg_q.cpu_y        <= 32'd65536;
			cfg_q.grid_columns <= 7'd64;
			cfg_q.grid_rows    <= 7'd64;
			cfg_q.net_filter   <= 2'd3;
			cfg_q.read_maximum <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORIGIN_X: cfg_q.origin_x     <= cfg_data[29:0];
				CFG_ORIGIN_Y: cfg_q.origin_y     <= cfg_data[29:0];
				CFG_CPU_X:    cfg_q.cpu_x        <= cfg_data;
				CFG_CPU_Y:    cfg_q.cpu_y        <= cfg_data;
				CFG_COLUMNS:  cfg_q.grid_columns <= cfg_data[6:0];
				CFG_ROWS:     cfg_q.grid_rows    <= cfg_data[6:0];
				CFG_FILTER:   cfg_q.net_filter   <= cfg_data[1:0];
				CFG_READ_MAX: cfg_q.read_maximum <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sbmm_front #(
		.NET_COUNT(NET_COUNT), .GRID_SIDE_MAX(GRID_SIDE_MAX), .AW(AW)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .clear_busy(clear_busy),
		.in_valid(sample_valid), .in_stall(sample_stall),
		.mode(mode), .net_select(net_select), .is_power(is_power),
		.coord_x(coord_x), .coord_y(coord_y), .metric_value(metric_value),
		.read_cell(read_cell),
		.push(push), .q_full(q_full), .push_entry(push_entry), .push_addr(push_addr)
	);

	sbmm_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata({push_entry, push_addr}),
		.pop(pop), .rdata({pop_entry, pop_addr}),
		.full(q_full), .empty(q_empty)
	);

	sbmm_back #(.DEPTH(DEPTH), .AW(AW)) u_back (
		.clk(clk), .arst_n(arst_n), .read_maximum(cfg_q.read_maximum),
		.clear_busy(clear_busy),
		.q_empty(q_empty), .q_entry(pop_entry), .q_addr(pop_addr), .pop(pop),
		.out_valid(result_valid), .out_stall(result_stall),
		.status(status), .cell_value(cell_value), .cell_empty(cell_empty)
	);

endmodule
`default_nettype wire

### bench/tb_spatial_bin_max_mean_accumulator_unit.sv
// Self-checking bench for spatial_bin_max_mean_accumulator_unit: drives add
// and read items, predicts every result with a behavioral grid store.
// Depends on sbmm_pkg and the RTL of the block.
`default_nettype none
module tb_spatial_bin_max_mean_accumulator_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import sbmm_pkg::*;

	localparam int NETS      = DEF_NET_COUNT;
	localparam int SIDE      = DEF_GRID_SIDE_MAX;
	localparam int NET_CELLS = SIDE * SIDE;
	localparam int DEPTH     = NETS * NET_CELLS;

	typedef struct packed {
		logic               mode;
		logic [1:0]         net;
		logic               pwr;
		logic signed [30:0] cx;
		logic signed [30:0] cy;
		logic signed [23:0] metric;
		logic [11:0]        rcell;
	} sample_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [23:0] value;
		logic               empty;
	} bin_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic mode = 1'b0;
	logic [1:0] net_select = '0;
	logic is_power = 1'b0;
	logic signed [30:0] coord_x = '0;
	logic signed [30:0] coord_y = '0;
	logic signed [23:0] metric_value = '0;
	logic [11:0] read_cell = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [1:0] status;
	logic signed [23:0] cell_value;
	logic cell_empty;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	spatial_bin_max_mean_accumulator_unit i_dut (
		.clk, .arst_n, .sample_valid, .sample_stall, .mode, .net_select,
		.is_power, .coord_x, .coord_y, .metric_value, .read_cell,
		.result_valid, .result_stall, .status, .cell_value, .cell_empty,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Predictor state: register copy and the per-net cell store
	cfg_t grid_cfg;
	logic signed [23:0] bin_max [DEPTH];
	logic signed [39:0] bin_sum [DEPTH];
	logic [15:0]        bin_count [DEPTH];

	bin_result_t pending_results[$];
	int errors = 0;
	int hold_cycles = 0;     // long receiver stall, counted down by stall process

	function automatic void predictor_reset();
		grid_cfg = '{origin_x: '0, origin_y: '0, cpu_x: 32'd65536,
			cpu_y: 32'd65536, grid_columns: 7'd64, grid_rows: 7'd64,
			net_filter: 2'd3, read_maximum: 1'b0};
		for (int i = 0; i < DEPTH; i++) begin
			bin_max[i] = -24'sd8388608;
			bin_sum[i] = '0;
			bin_count[i] = '0;
		end
	endfunction

	function automatic void config_apply(logic [2:0] idx, logic [31:0] d);
		case (idx)
			CFG_ORIGIN_X: grid_cfg.origin_x = d[29:0];
			CFG_ORIGIN_Y: grid_cfg.origin_y = d[29:0];
			CFG_CPU_X:    grid_cfg.cpu_x = d;
			CFG_CPU_Y:    grid_cfg.cpu_y = d;
			CFG_COLUMNS:  grid_cfg.grid_columns = d[6:0];
			CFG_ROWS:     grid_cfg.grid_rows = d[6:0];
			CFG_FILTER:   grid_cfg.net_filter = d[1:0];
			default:      grid_cfg.read_maximum = d[0];
		endcase
	endfunction

	// Coordinate to bin index; returns 0 when before origin or past limit
	function automatic bit axis_bin(logic signed [30:0] c, logic [29:0] org,
			logic [31:0] scale, int limit, output int idx);
		logic [63:0] prod;
		logic [63:0] bin;
		idx = 0;
		if (c < $signed({1'b0, org})) return 1'b0;
		prod = 64'(c - $signed({1'b0, org})) * 64'(scale);
		bin = prod >> 16;
		if (bin >= 64'(limit)) return 1'b0;
		idx = int'(bin);
		return 1'b1;
	endfunction

	function automatic bin_result_t bin_predict(sample_t s);
		bin_result_t r;
		int cols, rows, ix, iy, a;
		bit ok, okx, oky;
		logic signed [39:0] quot;
		r = '0;
		cols = (grid_cfg.grid_columns > SIDE) ? SIDE : int'(grid_cfg.grid_columns);
		rows = (grid_cfg.grid_rows > SIDE) ? SIDE : int'(grid_cfg.grid_rows);
		if (s.mode) begin
			if (int'(s.net) >= NETS || int'(s.rcell) >= cols * rows) begin
				r.status = ST_OUTSIDE;
				r.empty = 1'b1;
			end else begin
				a = int'(s.net) * NET_CELLS + int'(s.rcell);
				r.status = ST_OK;
				if (bin_count[a] == 0) r.empty = 1'b1;
				else if (grid_cfg.read_maximum) r.value = bin_max[a];
				else begin
					quot = bin_sum[a] / $signed({24'd0, bin_count[a]});
					r.value = quot[23:0];
				end
			end
			return r;
		end
		ok = s.pwr ? grid_cfg.net_filter[0] : grid_cfg.net_filter[1];
		okx = axis_bin(s.cx, grid_cfg.origin_x, grid_cfg.cpu_x, cols, ix);
		oky = axis_bin(s.cy, grid_cfg.origin_y, grid_cfg.cpu_y, rows, iy);
		if (!ok) r.status = ST_FILTER;
		else if (s.cx < 0 || s.cy < 0) r.status = ST_NOGEOM;
		else if (int'(s.net) >= NETS || !okx || !oky) r.status = ST_OUTSIDE;
		else begin
			r.status = ST_OK;
			a = int'(s.net) * NET_CELLS + iy * cols + ix;
			if (s.metric > bin_max[a]) bin_max[a] = s.metric;
			if (bin_count[a] != 16'hFFFF) begin
				bin_sum[a] += 40'(s.metric);
				bin_count[a] += 16'd1;
			end
		end
		return r;
	endfunction

	// Random gap: mostly short, a few long
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Fully random item bits
	function automatic sample_t rand_sample();
		logic [127:0] r;
		r = {$urandom, $urandom, $urandom, $urandom};
		return sample_t'(r[$bits(sample_t)-1:0]);
	endfunction

	// Receiver: random stall, plus a long hold-off on request
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				result_stall <= 1'b1;
				hold_cycles--;
			end else begin
				n = gap_len();
				result_stall <= (n != 0);
				repeat (n > 1 ? n - 1 : 0) @(posedge clk);
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		bin_result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d value=%0d empty=%0d",
					$time, status, cell_value, cell_empty);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, status);
					errors++;
				end
				if (cell_value !== exp_r.value) begin
					$display("%0t: cell_value expected %0d actual %0d", $time,
						exp_r.value, cell_value);
					errors++;
				end
				if (cell_empty !== exp_r.empty) begin
					$display("%0t: cell_empty expected %0d actual %0d", $time,
						exp_r.empty, cell_empty);
					errors++;
				end
			end
		end
	end

	bit sender_gaps = 1'b1;

	task automatic send_item(sample_t s);
		int n;
		if (sender_gaps) begin
			n = gap_len();
			if (n > 0) begin
				sample_valid <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
		sample_valid <= 1'b1;
		{mode, net_select, is_power, coord_x, coord_y, metric_value, read_cell} <= s;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		pending_results.insert(pending_results.size(), bin_predict(s));
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);   // margin for mean reads, which run through the divider
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		config_apply(idx, d);
		@(posedge clk);
	endtask

	function automatic sample_t add_at(logic [1:0] net, logic signed [30:0] x,
			logic signed [30:0] y, logic signed [23:0] m);
		sample_t s;
		s = '0;
		s.net = net;
		s.pwr = 1'($urandom_range(0, 1));
		s.cx = x;
		s.cy = y;
		s.metric = m;
		s.rcell = 12'($urandom);
		return s;
	endfunction

	function automatic sample_t read_at(logic [1:0] net, logic [11:0] c);
		sample_t s;
		s = rand_sample();
		s.mode = 1'b1;
		s.net = net;
		s.rcell = c;
		return s;
	endfunction

	// Directed: field extremes, filter, no geometry, outside, empty reads
	task automatic test_directed();
		sample_t s;
		send_item(read_at(2'd0, 12'd0));                  // empty cell
		send_item(add_at(2'd0, 31'sd0, 31'sd0, 24'sh7FFFFF));
		send_item(add_at(2'd0, 31'sd0, 31'sd0, -24'sd8388608));
		send_item(add_at(2'd0, 31'sd0, 31'sd0, -24'sd1));
		send_item(read_at(2'd0, 12'd0));                  // mean
		send_item(add_at(2'd3, 31'sd63, 31'sd63, 24'sd5));
		send_item(read_at(2'd3, 12'd4095));               // last cell of the grid
		send_item(read_at(2'd3, 12'd4095 - 12'd64 + 12'd1));
		send_item(add_at(2'd1, -31'sd1, 31'sd3, 24'sd1));     // no geometry
		send_item(add_at(2'd1, 31'sd3, -31'sd1073741824, 24'sd1));
		send_item(add_at(2'd1, 31'sd64, 31'sd0, 24'sd1));     // past columns
		send_item(add_at(2'd1, 31'sd1073741823, 31'sd1073741823, 24'sd1));
		drain();
		write_reg(CFG_READ_MAX, 32'd1);
		send_item(read_at(2'd0, 12'd0));
		send_item(read_at(2'd3, 12'd4095));
		drain();
		write_reg(CFG_FILTER, 32'd1);
		s = add_at(2'd2, 31'sd1, 31'sd1, 24'sd9);
		s.pwr = 1'b0;
		send_item(s);                                     // filtered ground
		s.pwr = 1'b1;
		send_item(s);
		drain();
		write_reg(CFG_FILTER, 32'd2);
		send_item(s);                                     // filtered power
		s.cx = -31'sd5;
		send_item(s);                                     // filter wins
		drain();
		write_reg(CFG_FILTER, 32'd0);
		s.pwr = 1'b0;
		send_item(s);
		drain();
		write_reg(CFG_FILTER, 32'd3);
	endtask

	// Origin offset, scaling, odd grid sizes including zero and saturation
	task automatic test_config_sweep();
		logic [31:0] settings [5][8];
		settings[0] = '{32'd100, 32'd200, 32'd32768, 32'd131072, 32'd10, 32'd7,
			32'd3, 32'd0};
		settings[1] = '{32'h3FFFFFFF, 32'h3FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'd127, 32'd127, 32'd3, 32'd1};
		settings[2] = '{32'd5, 32'd5, 32'd0, 32'd0, 32'd1, 32'd1, 32'd3, 32'd0};
		settings[3] = '{32'd0, 32'd0, 32'd65536, 32'd65536, 32'd0, 32'd0,
			32'd3, 32'd0};
		settings[4] = '{32'd1000, 32'd0, 32'd4096, 32'd20000, 32'd64, 32'd3,
			32'd2, 32'd1};
		for (int k = 0; k < 5; k++) begin
			for (int r = 0; r < 8; r++) write_reg(3'(r), settings[k][r]);
			for (int i = 0; i < 120; i++) random_item();
			drain();
		end
		for (int r = 0; r < 8; r++)
			write_reg(3'(r), r < 2 ? 32'd0 : r < 4 ? 32'd65536 :
				r < 6 ? 32'd8 : r == 6 ? 32'd3 : 32'd0);
	endtask

	// Mostly hits inside the configured window, some noise
	task automatic random_item();
		sample_t s;
		int cols, rows, p;
		logic [63:0] span_x, span_y;
		s = rand_sample();
		cols = (grid_cfg.grid_columns > SIDE) ? SIDE : int'(grid_cfg.grid_columns);
		rows = (grid_cfg.grid_rows > SIDE) ? SIDE : int'(grid_cfg.grid_rows);
		p = $urandom_range(0, 99);
		if (p < 70) begin
			span_x = grid_cfg.cpu_x == 0 ? 64'd1000 :
				(64'(cols) << 16) / grid_cfg.cpu_x + 2;
			span_y = grid_cfg.cpu_y == 0 ? 64'd1000 :
				(64'(rows) << 16) / grid_cfg.cpu_y + 2;
			s.cx = 31'(grid_cfg.origin_x + ($urandom % span_x)) & 31'h3FFFFFFF;
			s.cy = 31'(grid_cfg.origin_y + ($urandom % span_y)) & 31'h3FFFFFFF;
			s.net = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 3) == 0)
				s.metric = $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sd8388608;
			s.mode = ($urandom_range(0, 3) == 0);
			if (s.mode)
				s.rcell = 12'($urandom_range(0, cols * rows + 1));
		end
		send_item(s);
	endtask

	task automatic test_random();
		for (int i = 0; i < 1190; i++) random_item();
		drain();
	endtask

	// Long receiver hold-off while the sender keeps offering items
	task automatic test_backpressure();
		hold_cycles = 300;
		sender_gaps = 1'b0;
		for (int i = 0; i < 40; i++) random_item();
		sender_gaps = 1'b1;
		drain();
	endtask

	initial begin
		predictor_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// About 1850 items, some with long gaps and mean reads
	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
